// ===== rtl/core/csrank_pkg.sv =====
// ----------------------------------------------------------------------------
// csrank_pkg
// Shared constants, types and helpers of the caesar shift ranker.
// ----------------------------------------------------------------------------
package csrank_pkg;

	localparam int NUM_SHIFTS     = 26;
	localparam int SHIFT_W        = 5;
	localparam int SCORE_BITS_DEF = 16;
	localparam int OUT_SCORE_W    = 16;

	// bit i set where letter a+i is one of e,t,a,o,i,n,s,h,r,d,l,u
	localparam logic [NUM_SHIFTS-1:0] COMMON_MASK = 26'b00000_1111_0011_0100_1100_1100_1;

	// ascii letter bounds
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5A;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_Z = 8'h7A;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOAD
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic score_en;
		logic scan_init;
		logic scan_step;
		logic load_out;
		logic clear_run;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic rank_last;
		logic out_free;
	} dp_status_t;

	// letter index decoded under a shift, (idx - s) mod 26
	function automatic logic [SHIFT_W-1:0] decode_letter(
		input logic [SHIFT_W-1:0] idx,
		input logic [SHIFT_W-1:0] s
	);
		logic [SHIFT_W-1:0] r;
		if (idx >= s) begin
			r = idx - s;
		end else begin
			r = idx - s + SHIFT_W'(NUM_SHIFTS);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/csrank_in_if.sv =====
// ----------------------------------------------------------------------------
// csrank_in_if
// Ciphertext channel: one byte per beat with a last-byte mark.
// ----------------------------------------------------------------------------
interface csrank_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] cipher_byte;
	logic       final_byte;

	modport source (output valid, output cipher_byte, output final_byte, input ready);
	modport sink   (input valid, input cipher_byte, input final_byte, output ready);
endinterface

// ===== rtl/core/csrank_out_if.sv =====
// ----------------------------------------------------------------------------
// csrank_out_if
// Ranking channel: one ranked shift per beat.
// ----------------------------------------------------------------------------
interface csrank_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  rank;
	logic [4:0]  shift;
	logic [15:0] score;
	logic        end_of_ranking;

	modport source (output valid, output rank, output shift, output score,
		output end_of_ranking, input ready);
	modport sink   (input valid, input rank, input shift, input score,
		input end_of_ranking, output ready);
endinterface

// ===== rtl/core/csrank_ctrl.sv =====
// ----------------------------------------------------------------------------
// csrank_ctrl
// Sequencer: scores bytes, then walks the ranking one selection at a time.
// ----------------------------------------------------------------------------
module csrank_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_final,
	output logic                    in_ready,
	input  csrank_pkg::dp_status_t  status,
	output csrank_pkg::ctrl_cmd_t   cmd
);
	import csrank_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_final) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (status.scan_last) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.out_free) state_d = status.rank_last ? ST_IDLE : ST_SCAN;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.score_en  = in_valid;
				cmd.scan_init = in_valid && in_final;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_LOAD: begin
				cmd.load_out  = status.out_free;
				cmd.clear_run = status.out_free && status.rank_last;
				cmd.scan_init = status.out_free && !status.rank_last;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/csrank_dp.sv =====
// ----------------------------------------------------------------------------
// csrank_dp
// Score bank, selection scan and output register.
// ----------------------------------------------------------------------------
module csrank_dp #(
	parameter int SCORE_BITS = csrank_pkg::SCORE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  csrank_pkg::ctrl_cmd_t   cmd,
	output csrank_pkg::dp_status_t  status,
	input  logic [7:0]              cipher_byte,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [4:0]              out_rank,
	output logic [4:0]              out_shift,
	output logic [15:0]             out_score,
	output logic                    out_last
);
	import csrank_pkg::*;

	logic [SCORE_BITS-1:0] score_q [NUM_SHIFTS];
	logic [NUM_SHIFTS-1:0] hit;
	logic                  is_upper;
	logic                  is_lower;
	logic                  is_zero;
	logic [SHIFT_W-1:0]    letter_idx;

	logic [NUM_SHIFTS-1:0] done_q;
	logic [SHIFT_W-1:0]    scan_idx_q;
	logic [SHIFT_W-1:0]    rank_q;
	logic [SHIFT_W-1:0]    best_idx_q;
	logic [SCORE_BITS-1:0] best_score_q;
	logic                  best_valid_q;
	logic [SCORE_BITS-1:0] scan_score;
	logic                  take;
	logic [32:0]           best_wide;
	logic [15:0]           best_sat;

	logic                  out_valid_q;
	logic [4:0]            out_rank_q;
	logic [4:0]            out_shift_q;
	logic [15:0]           out_score_q;
	logic                  out_last_q;

	// byte classification
	assign is_upper   = (cipher_byte >= CH_UP_A) && (cipher_byte <= CH_UP_Z);
	assign is_lower   = (cipher_byte >= CH_LO_A) && (cipher_byte <= CH_LO_Z);
	assign is_zero    = (cipher_byte == 8'h00);
	assign letter_idx = is_lower ? SHIFT_W'(cipher_byte - CH_LO_A)
	                             : SHIFT_W'(cipher_byte - CH_UP_A);

	// per-shift hit flags
	always_comb begin
		for (int s = 0; s < NUM_SHIFTS; s++) begin
			hit[s] = is_zero || ((is_upper || is_lower) &&
				COMMON_MASK[decode_letter(letter_idx, SHIFT_W'(s))]);
		end
	end

	// saturating score bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SHIFTS; s++) score_q[s] <= '0;
		end else if (cmd.clear_run) begin
			for (int s = 0; s < NUM_SHIFTS; s++) score_q[s] <= '0;
		end else if (cmd.score_en) begin
			for (int s = 0; s < NUM_SHIFTS; s++) begin
				if (hit[s] && (score_q[s] != {SCORE_BITS{1'b1}})) begin
					score_q[s] <= score_q[s] + 1'b1;
				end
			end
		end
	end

	// selection scan: strict compare in ascending order keeps the lower shift on ties
	assign scan_score = score_q[scan_idx_q];
	assign take       = !done_q[scan_idx_q] && (!best_valid_q || (scan_score > best_score_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			best_valid_q <= 1'b0;
			best_idx_q   <= '0;
		end else if (cmd.scan_init) begin
			scan_idx_q   <= '0;
			best_valid_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!status.scan_last) scan_idx_q <= scan_idx_q + 1'b1;
			if (take) begin
				best_valid_q <= 1'b1;
				best_idx_q   <= scan_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && take) best_score_q <= scan_score;
	end

	// rank counter and selected marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
			done_q <= '0;
		end else if (cmd.load_out) begin
			if (cmd.clear_run) begin
				rank_q <= '0;
				done_q <= '0;
			end else begin
				rank_q             <= rank_q + 1'b1;
				done_q[best_idx_q] <= 1'b1;
			end
		end
	end

	// clamp wide scores to the result field
	assign best_wide = 33'(best_score_q);
	assign best_sat  = (best_wide > 33'h0_FFFF) ? 16'hFFFF : best_wide[15:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_rank_q  <= rank_q;
			out_shift_q <= best_idx_q;
			out_score_q <= best_sat;
			out_last_q  <= status.rank_last;
		end
	end

	assign status.scan_last = (scan_idx_q == SHIFT_W'(NUM_SHIFTS - 1));
	assign status.rank_last = (rank_q == SHIFT_W'(NUM_SHIFTS - 1));
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_rank  = out_rank_q;
	assign out_shift = out_shift_q;
	assign out_score = out_score_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	// a selection always finds a shift not yet ranked
	a_load_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (best_valid_q && !done_q[best_idx_q]))
		else $error("ranking load without a fresh selection");

	// never overwrite a beat that is still waiting
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while stalled");

	// end of a run leaves the bank and marks clear
	a_run_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_out && cmd.clear_run) |=> ((done_q == '0) && (rank_q == '0)
			&& (score_q[0] == '0)))
		else $error("state not cleared after last result");

	// the rank counts exactly the marked shifts
	a_rank_matches_marks: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(done_q) == int'(rank_q))
		else $error("rank counter out of step with selected shifts");
`endif

endmodule

// ===== rtl/core/caesar_shift_ranker_core.sv =====
// ----------------------------------------------------------------------------
// caesar_shift_ranker_core
// Frequency-scoring ranker over the 26 caesar decryption shifts.
// ----------------------------------------------------------------------------
// Usage:
//   text carries one ciphertext byte per beat; final_byte marks the last byte.
//   Each byte is scored in the cycle it is taken, all 26 shift scores in
//   parallel, so a text streams in at one byte per cycle.
//   After the final byte the block ranks the shifts by a selection walk: per
//   rank, the scan state walks the score bank through one compare unit, and
//   the load state moves the winner into the output register. text.ready is
//   low throughout the ranking, stalls included.
//   result carries rank, shift, score and end_of_ranking, 26 beats per text,
//   best first, ties to the lower shift; end_of_ranking marks the 26th.
//   When result is stalled the output register holds its beat and the walk
//   waits at the next load. Scores clear when the last beat is loaded, so the
//   next text may start while that beat is still waiting.
//   Reset (arst_n low) clears all scores and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module caesar_shift_ranker_core #(
	parameter int SCORE_BITS = csrank_pkg::SCORE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	csrank_in_if.sink   text,
	csrank_out_if.source result
);
	import csrank_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer
	csrank_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_final (text.final_byte),
		.in_ready (text.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// score bank and ranking datapath
	csrank_dp #(
		.SCORE_BITS (SCORE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cipher_byte (text.cipher_byte),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.out_rank    (result.rank),
		.out_shift   (result.shift),
		.out_score   (result.score),
		.out_last    (result.end_of_ranking)
	);

endmodule
